// ===== hdl/wie_pkg.sv =====
// shared types, constants and element id lookup for the information element parser
`default_nettype none

package wie_pkg;

   localparam int NUM_SLOTS = 10;
   localparam int SLOT_W    = 4;
   localparam int POS_W     = 11;
   localparam int LEN_W     = 8;
   localparam int BLEN_W    = 12;
   localparam int BYTE_W    = 8;

   localparam logic [SLOT_W-1:0] MIC_SLOT  = 4'd9;
   localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd9;

   typedef enum logic [1:0] {
      CAUSE_EXHAUSTED = 2'd0,
      CAUSE_OVERRUN   = 2'd1,
      CAUSE_MIC       = 2'd2
   } wie_cause_type;

   // controller to datapath
   typedef struct packed {
      logic start;       // new buffer: load length, clear table
      logic step;        // one buffer byte consumed
      logic load_id;     // capture element id
      logic load_body;   // capture body length
      logic body_step;   // one body byte consumed
      logic record;      // write current element into its slot
      logic emit_next;   // advance slot read counter
   } wie_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_short; // buffer too short for a header
      logic dec_short;   // fewer than two bytes left after this byte
      logic overrun;     // element length runs past the buffer end
      logic id_known;    // current id maps to a slot
      logic id_mic;      // current id is the mic element
      logic byte_zero;   // incoming byte is zero
      logic body_last;   // this is the last body byte
      logic slot_last;   // slot counter points at the last slot
   } wie_stat_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] idx;
   } wie_lookup_type;

   // published element numbers mapped to table slots
   function automatic wie_lookup_type slot_lookup(input logic [BYTE_W-1:0] id);
      wie_lookup_type r;
      r.hit = 1'b1;
      unique case (id)
         8'd1:    r.idx = 4'd0;
         8'd50:   r.idx = 4'd1;
         8'd48:   r.idx = 4'd2;
         8'd45:   r.idx = 4'd3;
         8'd61:   r.idx = 4'd4;
         8'd114:  r.idx = 4'd5;
         8'd117:  r.idx = 4'd6;
         8'd113:  r.idx = 4'd7;
         8'd139:  r.idx = 4'd8;
         8'd140:  r.idx = MIC_SLOT;
         default: begin
            r.hit = 1'b0;
            r.idx = 4'd0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/wie_dp.sv =====
// parser datapath: byte counters, current element, slot table and slot read counter
`default_nettype none

module wie_dp import wie_pkg::*; #(
   parameter int MAX_BUFFER_BYTES = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wie_cmd_type       cmd,
   input  wire logic [BLEN_W-1:0] buffer_length,
   input  wire logic [BYTE_W-1:0] data_byte,
   output      wie_stat_type      stat,
   output      logic [SLOT_W-1:0] slot_index,
   output      logic              slot_present,
   output      logic [POS_W-1:0]  body_offset,
   output      logic [LEN_W-1:0]  body_length
);

   localparam int BL_W  = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int CMP_W = (BL_W > BLEN_W) ? BL_W : BLEN_W;

   logic [BL_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] cur_id_ff, cur_id_in;
   logic [LEN_W-1:0]  body_left_ff, body_left_in;
   logic [SLOT_W-1:0] slot_cnt_ff, slot_cnt_in;

   logic              slot_valid_ff [NUM_SLOTS];
   logic [POS_W-1:0]  slot_offset_ff [NUM_SLOTS];
   logic [LEN_W-1:0]  slot_length_ff [NUM_SLOTS];

   logic [CMP_W-1:0]  blen_sat;
   logic [BL_W-1:0]   bl_dec;
   logic [POS_W-1:0]  pos_inc;
   wie_lookup_type    look;

   always_comb begin
      blen_sat = (CMP_W'(buffer_length) > CMP_W'(MAX_BUFFER_BYTES)) ?
                 CMP_W'(MAX_BUFFER_BYTES) : CMP_W'(buffer_length);
      bl_dec   = (bytes_left_ff != '0) ? bytes_left_ff - BL_W'(1) : '0;
      pos_inc  = pos_ff + POS_W'(1);
      look     = slot_lookup(cur_id_ff);

      stat.start_short = blen_sat < CMP_W'(2);
      stat.dec_short   = bl_dec < BL_W'(2);
      stat.overrun     = CMP_W'(data_byte) > CMP_W'(bl_dec);
      stat.id_known    = look.hit;
      stat.id_mic      = look.hit && (look.idx == MIC_SLOT);
      stat.byte_zero   = data_byte == '0;
      stat.body_last   = body_left_ff == LEN_W'(1);
      stat.slot_last   = slot_cnt_ff == LAST_SLOT;

      bytes_left_in = bytes_left_ff;
      pos_in        = pos_ff;
      cur_id_in     = cur_id_ff;
      body_left_in  = body_left_ff;
      slot_cnt_in   = slot_cnt_ff;

      if (cmd.start) begin
         bytes_left_in = blen_sat[BL_W-1:0];
         pos_in        = '0;
         cur_id_in     = '0;
         body_left_in  = '0;
      end
      if (cmd.step) begin
         bytes_left_in = bl_dec;
         pos_in        = pos_inc;
      end
      if (cmd.load_id)   cur_id_in    = data_byte;
      if (cmd.load_body) body_left_in = data_byte;
      if (cmd.body_step) body_left_in = body_left_ff - LEN_W'(1);
      if (cmd.emit_next) slot_cnt_in  = stat.slot_last ? '0 : slot_cnt_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         pos_ff        <= '0;
         cur_id_ff     <= '0;
         body_left_ff  <= '0;
         slot_cnt_ff   <= '0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         pos_ff        <= pos_in;
         cur_id_ff     <= cur_id_in;
         body_left_ff  <= body_left_in;
         slot_cnt_ff   <= slot_cnt_in;
      end
   end

   // slot table: valid bits cleared by reset and start, payload only written
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) slot_valid_ff[i] <= 1'b0;
      end else if (cmd.start) begin
         for (int i = 0; i < NUM_SLOTS; i++) slot_valid_ff[i] <= 1'b0;
      end else if (cmd.record && look.hit) begin
         slot_valid_ff[look.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.record && look.hit) begin
         slot_offset_ff[look.idx] <= pos_inc;
         slot_length_ff[look.idx] <= data_byte;
      end
   end

   always_comb begin
      slot_index   = slot_cnt_ff;
      slot_present = slot_valid_ff[slot_cnt_ff];
      body_offset  = slot_present ? slot_offset_ff[slot_cnt_ff] : '0;
      body_length  = slot_present ? slot_length_ff[slot_cnt_ff] : '0;
   end

endmodule

`default_nettype wire

// ===== hdl/wie_ctrl.sv =====
// parser controller: element phase walk and table dump sequencing
`default_nettype none

module wie_ctrl import wie_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_mode,
   input  wire logic         rsp_ready,
   input  wire wie_stat_type stat,
   output      wie_cmd_type  cmd,
   output      logic         req_ready,
   output      logic         rsp_valid,
   output      logic [1:0]   end_cause
);

   typedef enum logic [2:0] {
      ST_ID,
      ST_LEN,
      ST_BODY,
      ST_DONE,
      ST_EMIT
   } state_type;

   state_type     state_ff, state_in;
   wie_cause_type cause_ff, cause_in;
   logic          req_ready_ff, rsp_valid_ff;
   logic          take;

   assign take = req_valid && req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cause_in = cause_ff;
      cmd      = '0;

      if (take && !req_mode) begin
         cmd.start = 1'b1;
         if (stat.start_short) begin
            state_in = ST_EMIT;
            cause_in = CAUSE_EXHAUSTED;
         end else begin
            state_in = ST_ID;
         end
      end else begin
         unique case (state_ff)
            ST_ID: begin
               if (take) begin
                  cmd.step    = 1'b1;
                  cmd.load_id = 1'b1;
                  state_in    = ST_LEN;
               end
            end
            ST_LEN: begin
               if (take) begin
                  cmd.step = 1'b1;
                  if (stat.overrun) begin
                     state_in = ST_EMIT;
                     cause_in = CAUSE_OVERRUN;
                  end else if (stat.id_mic) begin
                     cmd.record = 1'b1;
                     state_in   = ST_EMIT;
                     cause_in   = CAUSE_MIC;
                  end else begin
                     cmd.record = stat.id_known;
                     if (!stat.byte_zero) begin
                        cmd.load_body = 1'b1;
                        state_in      = ST_BODY;
                     end else if (stat.dec_short) begin
                        state_in = ST_EMIT;
                        cause_in = CAUSE_EXHAUSTED;
                     end else begin
                        state_in = ST_ID;
                     end
                  end
               end
            end
            ST_BODY: begin
               if (take) begin
                  cmd.step      = 1'b1;
                  cmd.body_step = 1'b1;
                  if (stat.body_last) begin
                     if (stat.dec_short) begin
                        state_in = ST_EMIT;
                        cause_in = CAUSE_EXHAUSTED;
                     end else begin
                        state_in = ST_ID;
                     end
                  end
               end
            end
            ST_DONE: begin
               // data bytes are taken and dropped
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  cmd.emit_next = 1'b1;
                  if (stat.slot_last) state_in = ST_DONE;
               end
            end
            default: state_in = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DONE;
         cause_ff     <= CAUSE_EXHAUSTED;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cause_ff     <= cause_in;
         req_ready_ff <= state_in != ST_EMIT;
         rsp_valid_ff <= state_in == ST_EMIT;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign end_cause = cause_ff;

endmodule

`default_nettype wire

// ===== hdl/wlan_ie_tlv_parser_unit.sv =====
// top level of the 802.11 information element parser
`default_nettype none

// walks a buffer of 802.11 information elements (id byte, length byte, body)
// fed one byte per item. a start item (mode 0) loads the buffer length,
// saturated to MAX_BUFFER_BYTES, and clears the ten-slot table; data items
// (mode 1) bring the buffer bytes. known element ids record body offset and
// length in their slot, a repeat of an id overwrites it. parsing ends when
// fewer than two bytes remain for a header, when an element length overruns
// the buffer, or when a mic element is recorded; the block then sends ten
// result items, slots 0 to 9 in order, with the same end cause on each and
// last_slot on slot 9. while parsing, and after the end, one input item is
// taken every cycle. during the dump no input item is taken: the dump moves
// to the next slot whenever a result item is taken with rsp_ready high, as
// the slot table has a single read port walked by a slot counter. data items
// after the end of a parse are taken and dropped until the next start item.
module wlan_ie_tlv_parser_unit import wie_pkg::*; #(
   parameter int MAX_BUFFER_BYTES = 2048
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_mode,
   input  wire logic [BLEN_W-1:0] req_buffer_length,
   input  wire logic [BYTE_W-1:0] req_data_byte,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [SLOT_W-1:0] rsp_slot_index,
   output      logic              rsp_slot_present,
   output      logic [POS_W-1:0]  rsp_body_offset,
   output      logic [LEN_W-1:0]  rsp_body_length,
   output      logic [1:0]        rsp_end_cause,
   output      logic              rsp_last_slot
);

   wie_cmd_type  cmd;
   wie_stat_type stat;

   // phase walk and dump sequencing
   wie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .end_cause (rsp_end_cause)
   );

   // counters and slot table
   wie_dp #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .buffer_length (req_buffer_length),
      .data_byte     (req_data_byte),
      .stat          (stat),
      .slot_index    (rsp_slot_index),
      .slot_present  (rsp_slot_present),
      .body_offset   (rsp_body_offset),
      .body_length   (rsp_body_length)
   );

   assign rsp_last_slot = stat.slot_last;

   // no input item is taken during the dump
   a_no_take_in_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during table dump");

   // dump stops after the last slot
   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_slot |=> !rsp_valid)
      else $error("dump continued past last slot");

   // slots go out in order
   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_slot |=>
         rsp_valid && (rsp_slot_index == $past(rsp_slot_index) + 4'd1))
      else $error("slot sequence broken");

   // an empty slot reports zero offset and length
   a_empty_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_present |-> rsp_body_offset == '0 && rsp_body_length == '0)
      else $error("empty slot carries data");

endmodule

`default_nettype wire

// ===== tb/wlan_ie_tlv_parser_unit_tb.sv =====
// self-checking testbench for the information element parser top level
module wlan_ie_tlv_parser_unit_tb;
   import wie_pkg::*;

   localparam int MAX_BUFFER_BYTES = 2048;
   localparam int RANDOM_ITEMS     = 330;

   // item kinds on the request channel
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   // published element numbers, in slot order
   localparam logic [7:0] ID_RATES     = 8'd1;
   localparam logic [7:0] ID_EXT_RATES = 8'd50;
   localparam logic [7:0] ID_RSN       = 8'd48;
   localparam logic [7:0] ID_HT_CAP    = 8'd45;
   localparam logic [7:0] ID_HT_OP     = 8'd61;
   localparam logic [7:0] ID_MESH_ID   = 8'd114;
   localparam logic [7:0] ID_PEERING   = 8'd117;
   localparam logic [7:0] ID_MESH_CFG  = 8'd113;
   localparam logic [7:0] ID_AMPE      = 8'd139;
   localparam logic [7:0] ID_MIC       = 8'd140;

   typedef enum logic [1:0] {
      PH_ID,
      PH_LEN,
      PH_BODY,
      PH_DONE
   } walk_phase_type;

   // one table entry as the block reports it
   typedef struct {
      logic [SLOT_W-1:0] slot_index;
      logic              present;
      logic [POS_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      wie_cause_type     cause;
      logic              last;
   } slot_result_type;

   // one row of the directed stimulus; pinned rows carry a hand-written outcome
   typedef struct {
      logic              mode;
      logic [BLEN_W-1:0] blen;
      logic [BYTE_W-1:0] data;
      bit                pinned;
      bit                dumps;
      wie_cause_type     cause;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_START;
   logic [BLEN_W-1:0] req_buffer_length = '0;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic              rsp_slot_present;
   logic [POS_W-1:0]  rsp_body_offset;
   logic [LEN_W-1:0]  rsp_body_length;
   logic [1:0]        rsp_end_cause;
   logic              rsp_last_slot;

   logic [7:0] element_ids [NUM_SLOTS] = '{ID_RATES, ID_EXT_RATES, ID_RSN, ID_HT_CAP, ID_HT_OP,
                                           ID_MESH_ID, ID_PEERING, ID_MESH_CFG, ID_AMPE, ID_MIC};

   // directed part: extremes, every ending and the corner cases of the walk
   stim_row_type directed_rows [26] = '{
      '{MODE_DATA,  12'd0,   8'hFF,     1, 0, CAUSE_EXHAUSTED}, // data before any start
      '{MODE_START, 12'd0,   8'h00,     1, 1, CAUSE_EXHAUSTED}, // empty buffer ends at once
      '{MODE_START, 12'd1,   8'hFF,     1, 1, CAUSE_EXHAUSTED}, // one byte cannot hold a header
      '{MODE_DATA,  12'hFFF, 8'hAB,     1, 0, CAUSE_EXHAUSTED}, // dropped after the end
      '{MODE_START, 12'hFFF, 8'h00,     1, 0, CAUSE_EXHAUSTED}, // saturated to the max length
      '{MODE_START, 12'd2,   8'h00,     0, 0, CAUSE_EXHAUSTED}, // restart abandons that parse
      '{MODE_DATA,  12'd0,   ID_RATES,  0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'd0,      0, 0, CAUSE_EXHAUSTED}, // zero-length body, buffer used up
      '{MODE_START, 12'd5,   8'h00,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'hFF,     0, 0, CAUSE_EXHAUSTED}, // unknown id
      '{MODE_DATA,  12'd0,   8'd4,      1, 1, CAUSE_OVERRUN},   // 4 body bytes, 3 left
      '{MODE_START, 12'd12,  8'h00,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   ID_RSN,    0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'd2,      0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'h00,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'hFF,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   ID_RSN,    0, 0, CAUSE_EXHAUSTED}, // repeat id overwrites the slot
      '{MODE_DATA,  12'd0,   8'd1,      0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'h5A,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   ID_MIC,    0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'd0,      0, 0, CAUSE_EXHAUSTED}, // mic recorded, parse ends
      '{MODE_START, 12'd4,   8'h00,     0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   ID_HT_CAP, 0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'd1,      0, 0, CAUSE_EXHAUSTED},
      '{MODE_DATA,  12'd0,   8'h77,     0, 0, CAUSE_EXHAUSTED}, // one byte left, parse ends
      '{MODE_DATA,  12'd0,   8'h3C,     1, 0, CAUSE_EXHAUSTED}  // stray tail byte is dropped
   };

   // parser state as predicted from the accepted items
   walk_phase_type phase = PH_DONE;
   logic [11:0] remaining = '0;
   logic [11:0] pos = '0;
   logic [7:0]  elem_id = '0;
   logic [7:0]  body_left = '0;
   bit          slot_seen [NUM_SLOTS];
   logic [11:0] slot_off [NUM_SLOTS];
   logic [7:0]  slot_len [NUM_SLOTS];

   slot_result_type table_dump [$];    // entries produced by the latest item
   slot_result_type pending_slots [$]; // entries still to come from the block
   slot_result_type head;

   int  error_count = 0;
   int  items_taken = 0;
   bit  calm = 1'b0;
   int  calm_left = 0;
   int  stall_left = 0;

   wlan_ie_tlv_parser_unit #(
      .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_buffer_length(req_buffer_length),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_slot_index(rsp_slot_index),
      .rsp_slot_present(rsp_slot_present),
      .rsp_body_offset(rsp_body_offset),
      .rsp_body_length(rsp_body_length),
      .rsp_end_cause(rsp_end_cause),
      .rsp_last_slot(rsp_last_slot)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // generous bound on the whole run
   initial begin
      #6000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly short idles, now and then a long one
   function automatic int idle_cycles();
      if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // slot of a known element id, -1 for any other id
   function automatic int id_slot(input logic [7:0] id);
      int i;
      for (i = 0; i < NUM_SLOTS; i++) begin
         if (element_ids[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic void clear_table();
      int i;
      for (i = 0; i < NUM_SLOTS; i++) begin
         slot_seen[i] = 1'b0;
         slot_off[i]  = '0;
         slot_len[i]  = '0;
      end
   endfunction

   // end of parse: all ten slots go out with the same cause
   task automatic dump_table(input wie_cause_type cause);
      slot_result_type r;
      int i;
      phase = PH_DONE;
      for (i = 0; i < NUM_SLOTS; i++) begin
         r.slot_index = SLOT_W'(i);
         r.present    = slot_seen[i];
         r.offset     = slot_seen[i] ? slot_off[i][POS_W-1:0] : '0;
         r.length     = slot_seen[i] ? slot_len[i] : '0;
         r.cause      = cause;
         r.last       = (i == NUM_SLOTS - 1);
         table_dump.push_back(r);
      end
   endtask

   // after a whole element: another header fits or the buffer is used up
   task automatic close_element();
      if (remaining < 12'd2) dump_table(CAUSE_EXHAUSTED);
      else phase = PH_ID;
   endtask

   // advance the predicted parse by one accepted item
   task automatic walk_item(input logic m, input logic [11:0] bl, input logic [7:0] db);
      int s;
      table_dump.delete();
      if (m == MODE_START) begin
         remaining = (bl > 12'(MAX_BUFFER_BYTES)) ? 12'(MAX_BUFFER_BYTES) : bl;
         pos       = '0;
         elem_id   = '0;
         body_left = '0;
         clear_table();
         close_element();
      end else begin
         case (phase)
            PH_ID: begin
               elem_id   = db;
               remaining = remaining - 1;
               pos       = pos + 1;
               phase     = PH_LEN;
            end
            PH_LEN: begin
               remaining = remaining - 1;
               pos       = pos + 1;
               if ({4'd0, db} > remaining) begin
                  dump_table(CAUSE_OVERRUN);
               end else begin
                  s = id_slot(elem_id);
                  if (s >= 0) begin
                     slot_seen[s] = 1'b1;
                     slot_off[s]  = pos;
                     slot_len[s]  = db;
                  end
                  if (s == int'(MIC_SLOT)) begin
                     dump_table(CAUSE_MIC);
                  end else if (db == 8'd0) begin
                     close_element();
                  end else begin
                     body_left = db;
                     phase     = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               body_left = body_left - 1;
               if (remaining > 0) remaining = remaining - 1;
               pos = pos + 1;
               if (body_left == 8'd0) close_element();
            end
            default: begin
            end
         endcase
      end
   endtask

   // offer one item, wait for it to be taken, then book its expected results
   task automatic send_item(input logic m, input logic [11:0] bl, input logic [7:0] db,
                            input bit pinned = 0, input bit dumps = 0,
                            input wie_cause_type cause = CAUSE_EXHAUSTED);
      int gap;
      int i;
      slot_result_type r;
      gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_buffer_length <= bl;
      req_data_byte     <= db;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // dropped data items do not count toward the random budget
      if (m == MODE_START || phase != PH_DONE) items_taken++;
      walk_item(m, bl, db);
      if (pinned) begin
         if (dumps) begin
            for (i = 0; i < NUM_SLOTS; i++) begin
               r.slot_index = SLOT_W'(i);
               r.present    = 1'b0;
               r.offset     = '0;
               r.length     = '0;
               r.cause      = cause;
               r.last       = (SLOT_W'(i) == LAST_SLOT);
               pending_slots.push_back(r);
            end
         end
      end else begin
         foreach (table_dump[i]) pending_slots.push_back(table_dump[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // stretches of back-to-back traffic on both sides now and then
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm      <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(100, 400);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         stall_left <= idle_cycles() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each taken result with the oldest expected entry
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_slots.size() == 0) begin
            $error("result item for slot %0d with nothing expected", rsp_slot_index);
            error_count++;
         end else begin
            head = pending_slots.pop_front();
            check_field("slot_index", 12'(head.slot_index), 12'(rsp_slot_index));
            check_field("slot_present", 12'(head.present), 12'(rsp_slot_present));
            check_field("body_offset", 12'(head.offset), 12'(rsp_body_offset));
            check_field("body_length", 12'(head.length), 12'(rsp_body_length));
            check_field("end_cause", 12'(head.cause), 12'(rsp_end_cause));
            check_field("last_slot", 12'(head.last), 12'(rsp_last_slot));
         end
      end
   end

   initial begin
      int random_goal;
      int len;
      int room;
      int total;
      int walk_limit;
      int r;
      int n;
      int k;
      logic [7:0] id;

      clear_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].mode, directed_rows[i].blen, directed_rows[i].data,
                   directed_rows[i].pinned, directed_rows[i].dumps, directed_rows[i].cause);
      end

      // random part: mostly well-formed buffers, some noise
      random_goal = items_taken + RANDOM_ITEMS;
      while (items_taken < random_goal) begin
         if ($urandom_range(0, 9) == 0) begin
            // broken buffer: random bytes after a start
            n = $urandom_range(0, 12);
            send_item(MODE_START, 12'($urandom_range(0, 40)), 8'($urandom));
            repeat (n) send_item(MODE_DATA, 12'($urandom), 8'($urandom));
         end else begin
            r          = $urandom_range(0, 99);
            walk_limit = MAX_BUFFER_BYTES;
            if (r < 80) begin
               total = $urandom_range(0, 30);
            end else if (r < 94) begin
               total = $urandom_range(31, 120);
            end else begin
               // any length, saturation included; only the first bytes are walked
               total      = $urandom_range(0, 4095);
               walk_limit = $urandom_range(10, 60);
            end
            send_item(MODE_START, 12'(total), 8'($urandom));
            while (phase != PH_DONE && pos < 12'(walk_limit)) begin
               // sometimes give up mid-buffer; the next start restarts the parse
               if ($urandom_range(0, 99) < 3) break;
               r = $urandom_range(0, 99);
               if (r < 5) id = ID_MIC;
               else if (r < 75) id = element_ids[$urandom_range(0, NUM_SLOTS - 2)];
               else id = 8'($urandom);
               room = int'(remaining) - 2;
               r = $urandom_range(0, 99);
               if (r < 7 && room < 255) len = $urandom_range(room + 1, 255);
               else if (r < 20 || room == 0) len = 0;
               else if (r < 30) len = $urandom_range(1, (room < 255) ? room : 255);
               else len = $urandom_range(1, (room < 12) ? room : 12);
               send_item(MODE_DATA, 12'($urandom), id);
               send_item(MODE_DATA, 12'($urandom), 8'(len));
               for (k = 0; k < len && phase == PH_BODY; k++) begin
                  send_item(MODE_DATA, 12'($urandom), 8'($urandom));
               end
            end
            // trailing bytes, dropped by the block once the parse is over
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) send_item(MODE_DATA, 12'($urandom), 8'($urandom));
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      // room for any stray result after the last dump
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/wie_pkg.sv
hdl/wie_dp.sv
hdl/wie_ctrl.sv
hdl/wlan_ie_tlv_parser_unit.sv
tb/wlan_ie_tlv_parser_unit_tb.sv
